// ----- hw/rtl/multiplexed_bargraph_scanner_core_macros.svh -----
// Assertion macros used by the bargraph scanner checker.
`ifndef MULTIPLEXED_BARGRAPH_SCANNER_CORE_MACROS_SVH
`define MULTIPLEXED_BARGRAPH_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, skipped while reset is high
`define MBSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bargraph scanner check failed");

// Next-cycle implication, skipped while reset is high
`define MBSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bargraph scanner check failed");

`endif

// ----- hw/rtl/mbsc_pkg.sv -----
// Shared types, widths and the row decode of the bargraph scanner.
package mbsc_pkg;

   localparam int LEVEL_W  = 8;
   localparam int INDEX_W  = 4;
   localparam int SELECT_W = 3;
   localparam int ROWS     = 20;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   // Dead-time cycle: blank, drive, blank
   typedef enum logic [2:0] {
      PHASE_LEAD  = 3'b001,
      PHASE_DRIVE = 3'b010,
      PHASE_TRAIL = 3'b100
   } phase_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] column;
      logic [LEVEL_W-1:0] level;
   } store_wr_type;

   typedef struct packed {
      logic [SELECT_W-1:0] column_select;
      logic                low_columns_enable;
      logic [ROWS-1:0]     row_drive;
   } rsp_type;

   // Thermometer code of a level; blank above the row count
   function automatic logic [ROWS-1:0] thermometer(input logic [LEVEL_W-1:0] level);
      logic [ROWS-1:0] rows;
      rows = '0;
      for (int i = 0; i < ROWS; i++) begin
         rows[i] = (level > LEVEL_W'(i)) && (level <= LEVEL_W'(ROWS));
      end
      return rows;
   endfunction

endpackage

// ----- hw/rtl/mbsc_if.sv -----
// Valid/ready channel interfaces for command beats and display beats.
interface mbsc_req_if;
   import mbsc_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic [INDEX_W-1:0] column_index;
   logic [LEVEL_W-1:0] bar_level;

   modport source (output valid, output command, output column_index,
                   output bar_level, input ready);
   modport sink   (input valid, input command, input column_index,
                   input bar_level, output ready);
endinterface

interface mbsc_rsp_if;
   import mbsc_pkg::*;

   logic                valid;
   logic                ready;
   logic [SELECT_W-1:0] column_select;
   logic                low_columns_enable;
   logic [ROWS-1:0]     row_drive;

   modport source (output valid, output column_select, output low_columns_enable,
                   output row_drive, input ready);
   modport sink   (input valid, input column_select, input low_columns_enable,
                   input row_drive, output ready);
endinterface

// ----- hw/rtl/mbsc_level_store.sv -----
// Per-column level registers with one write port and one read port.
module mbsc_level_store #(
   parameter int COLUMNS = 9
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mbsc_pkg::store_wr_type                 wr,
   input  logic [$clog2(COLUMNS)-1:0]             rd_column,
   output logic [mbsc_pkg::LEVEL_W-1:0]           rd_level
);
   import mbsc_pkg::*;

   localparam int IdxW = $clog2(COLUMNS);

   logic [LEVEL_W-1:0] level_ff [COLUMNS];
   logic [LEVEL_W-1:0] level_in [COLUMNS];

   // Store the level only for a column that exists
   always_comb begin
      level_in = level_ff;
      if (wr.en && (wr.column < INDEX_W'(COLUMNS))) begin
         level_in[wr.column[IdxW-1:0]] = wr.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         level_ff <= level_in;
      end
   end

   // Read the active column
   always_comb begin
      rd_level = '0;
      if (rd_column < IdxW'(COLUMNS)) begin
         rd_level = level_ff[rd_column];
      end
   end

endmodule

// ----- hw/rtl/mbsc_phase_seq.sv -----
// Dead-time phase sequencer, column scan and held select lines.
module mbsc_phase_seq #(
   parameter int COLUMNS = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick,
   input  logic [mbsc_pkg::LEVEL_W-1:0]   level,
   output logic [$clog2(COLUMNS)-1:0]     rd_column,
   output mbsc_pkg::rsp_type              result
);
   import mbsc_pkg::*;

   localparam int ColW    = $clog2(COLUMNS);
   localparam int LowCols = 2 ** SELECT_W;

   phase_type           phase_ff, phase_in, step_phase;
   logic [ColW-1:0]     column_ff, column_in, step_column;
   logic [SELECT_W-1:0] select_ff, select_in, step_select;
   logic                enable_ff, enable_in, step_enable;
   logic [ROWS-1:0]     step_rows;

   assign rd_column = column_ff;

   // Work out one tick from the current phase
   always_comb begin
      step_phase  = phase_ff;
      step_column = column_ff;
      step_select = select_ff;
      step_enable = enable_ff;
      step_rows   = '0;
      case (phase_ff)
         PHASE_DRIVE: begin
            step_rows   = thermometer(level);
            step_column = (column_ff == ColW'(COLUMNS - 1)) ? '0 : column_ff + ColW'(1);
            step_phase  = PHASE_TRAIL;
         end
         PHASE_TRAIL: begin
            step_phase = PHASE_LEAD;
         end
         default: begin
            // Latch select lines; the top column has no low select
            if (column_ff < ColW'(LowCols)) begin
               step_enable = 1'b1;
               step_select = column_ff[SELECT_W-1:0];
            end else begin
               step_enable = 1'b0;
               step_select = '0;
            end
            step_phase = PHASE_DRIVE;
         end
      endcase
   end

   // Advance only on a tick beat
   always_comb begin
      phase_in  = tick ? step_phase  : phase_ff;
      column_in = tick ? step_column : column_ff;
      select_in = tick ? step_select : select_ff;
      enable_in = tick ? step_enable : enable_ff;
   end

   assign result.column_select      = step_select;
   assign result.low_columns_enable = step_enable;
   assign result.row_drive          = step_rows;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_LEAD;
         column_ff <= '0;
         select_ff <= '0;
         enable_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         column_ff <= column_in;
         select_ff <= select_in;
         enable_ff <= enable_in;
      end
   end

endmodule

// ----- hw/rtl/multiplexed_bargraph_scanner_core.sv -----
// Bargraph scanner top level: input register, sequencer, level store, output register.
//
// Usage:
//   req_chan carries command beats. command = 1 writes bar_level into the
//   column given by column_index (columns 0..8; others are dropped) and
//   yields no display beat. command = 0 is a display tick and yields
//   exactly one beat on rsp_chan with column_select, low_columns_enable and
//   row_drive for the current step of the blank / drive / blank cycle.
//   A tick accepted on req_chan is held in the input register, then moves to
//   the output register, which drives its beat on rsp_chan. Throughput: one
//   beat per cycle on either channel while rsp_chan does not stall; the phase
//   step and row decode are a single pass of logic between the registers.
//   Reset (synchronous) clears all column levels, the phase, the scan
//   column and the held select lines, and empties both registers.
//   When rsp_chan stalls, the display beat holds in the output register,
//   writes keep flowing through, and a tick waits in the input register;
//   req_chan.ready drops only while a tick is waiting there.
module multiplexed_bargraph_scanner_core #(
   parameter int COLUMNS = 9
) (
   input  logic              clock,
   input  logic              reset,
   mbsc_req_if.sink          req_chan,
   mbsc_rsp_if.source        rsp_chan
);
   import mbsc_pkg::*;

   localparam int ColW = $clog2(COLUMNS);

   logic               in_valid_ff, in_valid_in;
   logic               in_cmd_ff;
   logic [INDEX_W-1:0] in_column_ff;
   logic [LEVEL_W-1:0] in_level_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic               out_free;
   logic               in_fire;
   logic               tick_fire;
   logic               req_fire;
   store_wr_type       store_wr;
   logic [ColW-1:0]    rd_column;
   logic [LEVEL_W-1:0] rd_level;
   rsp_type            step_rsp;

   // Handshake: writes drain freely, ticks need a free output slot
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign in_fire   = in_valid_ff && ((in_cmd_ff == CMD_WRITE) || out_free);
   assign tick_fire = in_fire && (in_cmd_ff == CMD_TICK);
   assign req_chan.ready = !in_valid_ff || in_fire;
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign store_wr.en     = in_fire && (in_cmd_ff == CMD_WRITE);
   assign store_wr.column = in_column_ff;
   assign store_wr.level  = in_level_ff;

   mbsc_level_store #(.COLUMNS(COLUMNS)) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (store_wr),
      .rd_column (rd_column),
      .rd_level  (rd_level)
   );

   mbsc_phase_seq #(.COLUMNS(COLUMNS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick_fire),
      .level     (rd_level),
      .rd_column (rd_column),
      .result    (step_rsp)
   );

   // Input register occupancy
   assign in_valid_in = req_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);

   // Output register occupancy
   assign rsp_valid_in = tick_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads; no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff    <= req_chan.command;
         in_column_ff <= req_chan.column_index;
         in_level_ff  <= req_chan.bar_level;
      end
      if (tick_fire) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.column_select      = rsp_data_ff.column_select;
   assign rsp_chan.low_columns_enable = rsp_data_ff.low_columns_enable;
   assign rsp_chan.row_drive          = rsp_data_ff.row_drive;

endmodule

// ----- hw/rtl/mbsc_checker.sv -----
// Port-level checks on the bargraph scanner display channel, bound to the top level.
`include "multiplexed_bargraph_scanner_core_macros.svh"

module mbsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mbsc_pkg::SELECT_W-1:0] column_select,
   input logic                          low_columns_enable,
   input logic [mbsc_pkg::ROWS-1:0]     row_drive
);
   import mbsc_pkg::*;

   // A stalled display beat holds
   `MBSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(row_drive) && $stable(column_select))

   // Rows always form a thermometer code
   `MBSC_ASSERT_SAME(a_rows_thermo, clock, reset, rsp_valid,
                     (row_drive & (row_drive + ROWS'(1))) == '0)

   // A nonzero low select only comes with the low columns enabled
   `MBSC_ASSERT_SAME(a_select_enable, clock, reset, rsp_valid && (column_select != '0),
                     low_columns_enable)

   // No display beat right after reset
   `MBSC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind multiplexed_bargraph_scanner_core mbsc_checker u_mbsc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .column_select      (rsp_chan.column_select),
   .low_columns_enable (rsp_chan.low_columns_enable),
   .row_drive          (rsp_chan.row_drive)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the multiplexed bargraph scanner core.
module tb_top;
   import mbsc_pkg::*;

   localparam int COLUMN_COUNT  = 9;
   localparam int DIRECTED_ROWS = 25;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;

   // One row of the directed stimulus; beat is used only when typed is set
   typedef struct packed {
      cmd_type            cmd;
      logic [INDEX_W-1:0] column;
      logic [LEVEL_W-1:0] level;
      logic               typed;
      rsp_type            beat;
   } directed_row_type;

   localparam directed_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // after reset: column 0 selected, tick fields ignored
      '{CMD_TICK,  4'd15, 8'd255, 1'b1, '{3'd0, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd0, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd0, 1'b1, 20'h00000}},
      // full bar, then writes to columns that do not exist
      '{CMD_WRITE, 4'd1,  8'd20,  1'b0, '0},
      '{CMD_WRITE, 4'd9,  8'd77,  1'b0, '0},
      '{CMD_WRITE, 4'd15, 8'd255, 1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd1, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd1, 1'b1, 20'hFFFFF}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd1, 1'b1, 20'h00000}},
      // one above the row count blanks the column
      '{CMD_WRITE, 4'd2,  8'd21,  1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd2, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd2, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd2, 1'b1, 20'h00000}},
      // single segment
      '{CMD_WRITE, 4'd3,  8'd1,   1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd3, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd3, 1'b1, 20'h00001}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd3, 1'b1, 20'h00000}},
      // top level value blanks too
      '{CMD_WRITE, 4'd4,  8'd255, 1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd4, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd4, 1'b1, 20'h00000}},
      '{CMD_TICK,  4'd0,  8'd0,   1'b1, '{3'd4, 1'b1, 20'h00000}},
      // mid level, checked against the scan predictor
      '{CMD_WRITE, 4'd5,  8'd10,  1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b0, '0},
      '{CMD_TICK,  4'd0,  8'd0,   1'b0, '0}
   };

   logic clock;
   logic reset;

   mbsc_req_if req_bus ();
   mbsc_rsp_if rsp_bus ();

   multiplexed_bargraph_scanner_core #(
      .COLUMNS (COLUMN_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Scan predictor state
   logic [LEVEL_W-1:0]  col_levels [COLUMN_COUNT];
   logic [INDEX_W-1:0]  scan_column;
   phase_type           scan_phase;
   logic [SELECT_W-1:0] held_select;
   logic                held_enable;

   rsp_type expected_scans [$];

   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   bit hold_served;
   int hold_left;
   int mismatches;
   int beats_seen;
   int idle_cycles;
   int writes_kept;
   int writes_dropped;
   int ticks_sent;
   int edge_beats;
   int full_bars;

   // Thermometer of a level; blank above the row count
   function automatic logic [ROWS-1:0] bar_rows(input logic [LEVEL_W-1:0] level);
      logic [ROWS:0] ones;
      ones = (21'd1 << level) - 21'd1;
      if (level > LEVEL_W'(ROWS)) begin
         return '0;
      end
      return ones[ROWS-1:0];
   endfunction

   // Step the scan model by one command beat
   task automatic predict_scan(input cmd_type cmd, input logic [INDEX_W-1:0] column,
                               input logic [LEVEL_W-1:0] level, output bit produces,
                               output rsp_type beat);
      logic [ROWS-1:0] rows;
      rows = '0;
      beat = '0;
      produces = 1'b0;
      if (cmd == CMD_WRITE) begin
         if (column < COLUMN_COUNT) begin
            col_levels[column] = level;
            writes_kept++;
         end else begin
            writes_dropped++;
         end
      end else begin
         produces = 1'b1;
         ticks_sent++;
         case (scan_phase)
            PHASE_DRIVE: begin
               rows = bar_rows(col_levels[scan_column]);
               scan_column = (scan_column == COLUMN_COUNT - 1) ? '0 : scan_column + INDEX_W'(1);
               scan_phase = PHASE_TRAIL;
            end
            PHASE_TRAIL: begin
               scan_phase = PHASE_LEAD;
            end
            default: begin
               held_enable = (scan_column < 8);
               held_select = held_enable ? scan_column[SELECT_W-1:0] : '0;
               scan_phase = PHASE_DRIVE;
            end
         endcase
         beat.column_select      = held_select;
         beat.low_columns_enable = held_enable;
         beat.row_drive          = rows;
         if (!held_enable) edge_beats++;
         if (rows == '1) full_bars++;
      end
   endtask

   // Offer one command beat, wait for acceptance, record what it should cause
   task automatic offer_command(input cmd_type cmd, input logic [INDEX_W-1:0] column,
                                input logic [LEVEL_W-1:0] level, input bit use_typed,
                                input rsp_type typed_beat);
      bit      produces;
      rsp_type beat;
      while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.column_index <= column;
      req_bus.bar_level    <= level;
      do @(posedge clock); while (!req_bus.ready);
      predict_scan(cmd, column, level, produces, beat);
      if (produces) begin
         expected_scans.push_back(use_typed ? typed_beat : beat);
      end
   endtask

   // Random command: mostly ticks and in-range writes, some dropped writes
   task automatic offer_random;
      int      pick;
      cmd_type cmd;
      logic [INDEX_W-1:0] column;
      logic [LEVEL_W-1:0] level;
      pick = $urandom_range(99);
      column = INDEX_W'($urandom_range(15));
      level = LEVEL_W'($urandom_range(255));
      if (pick < 50) begin
         cmd = CMD_TICK;
      end else if (pick < 90) begin
         cmd = CMD_WRITE;
         column = INDEX_W'($urandom_range(COLUMN_COUNT - 1));
         if ($urandom_range(9) < 7) level = LEVEL_W'($urandom_range(ROWS + 1));
      end else begin
         cmd = CMD_WRITE;
         column = INDEX_W'($urandom_range(15, COLUMN_COUNT));
      end
      offer_command(cmd, column, level, 1'b0, '0);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      hold_served = 1'b0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
         @(posedge clock);
      end
   end

   // Check each display beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_seen++;
         if (expected_scans.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("tb_top: unexpected beat %0d: sel=%0d en=%0d rows=%05h", beats_seen,
                        rsp_bus.column_select, rsp_bus.low_columns_enable, rsp_bus.row_drive);
            end
         end else begin
            want = expected_scans.pop_front();
            if (rsp_bus.column_select !== want.column_select ||
                rsp_bus.low_columns_enable !== want.low_columns_enable ||
                rsp_bus.row_drive !== want.row_drive) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("tb_top: beat %0d exp sel/en/rows %0d/%0d/%05h, got %0d/%0d/%05h",
                           beats_seen, want.column_select, want.low_columns_enable,
                           want.row_drive, rsp_bus.column_select,
                           rsp_bus.low_columns_enable, rsp_bus.row_drive);
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("tb_top: no progress for %0d cycles", STALL_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_TICK;
      req_bus.column_index <= '0;
      req_bus.bar_level    <= '0;
      reset <= 1'b1;
      idle_cycles = 0;
      mismatches = 0;
      beats_seen = 0;
      writes_kept = 0;
      writes_dropped = 0;
      ticks_sent = 0;
      edge_beats = 0;
      full_bars = 0;
      hold_request = 1'b0;
      tx_idle_pct = 14;
      rx_idle_pct = 69;
      for (int k = 0; k < COLUMN_COUNT; k++) col_levels[k] = '0;
      scan_column = '0;
      scan_phase  = PHASE_LEAD;
      held_select = '0;
      held_enable = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         offer_command(DIRECTED[r].cmd, DIRECTED[r].column, DIRECTED[r].level,
                       DIRECTED[r].typed, DIRECTED[r].beat);
      end

      // Random traffic: slow receiver, slow sender, then full rate with one long hold-off
      repeat (600) offer_random();
      tx_idle_pct = 69;
      rx_idle_pct = 14;
      repeat (600) offer_random();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request = 1'b1;
      repeat (625) offer_random();
      req_bus.valid <= 1'b0;

      // Drain outstanding beats
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d ticks, %0d beats checked, %0d column-8 beats, %0d full bars",
               ticks_sent, beats_seen, edge_beats, full_bars);
      $display("tb_top: %0d level writes stored, %0d out-of-range writes dropped",
               writes_kept, writes_dropped);
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
